/* rtl/lksc_pkg.sv */
package lksc_pkg;

   localparam int NUM_SLOTS_DEFAULT = 8;

   localparam int KEY_W      = 64;
   localparam int STAMP_W    = 64;
   localparam int FUNC_W     = 2;
   localparam int TARGET_W   = 3;
   localparam int SLOT_W     = 3;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOOKUP     = 2'd0,
      FUNC_INVALIDATE = 2'd1,
      FUNC_CLEAR      = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic hit;
      logic evicted;
   } pick_type;

endpackage

/* rtl/lru_keyed_slot_cache.sv */
// lookup: response registered after the slot scan, the table write and the hold state
// invalidate, clear and unused codes: response registered from the hold state
// one request at a time; the slot scan reads one entry a cycle from the key and stamp store
// the next request is taken once the previous result sits in the output register
// synchronous reset empties all slots and zeroes the use counter; keys need no clearing
module lru_keyed_slot_cache #(
   parameter int NUM_SLOTS = lksc_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // surface_key, generation_key, target_slot, zero pad
   input  logic [lksc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func
   input  logic [lksc_pkg::FUNC_W-1:0]        req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hit, slot, evicted, zero pad
   output logic [lksc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int CMP_W = 7;

   lksc_pkg::state_type          state_ff, state_in;
   logic [NUM_SLOTS-1:0]         valid_ff, valid_in;
   logic [lksc_pkg::STAMP_W-1:0] counter_ff, counter_in;
   logic [lksc_pkg::KEY_W-1:0]   surface_ff, surface_in;
   logic [lksc_pkg::KEY_W-1:0]   generation_ff, generation_in;
   logic [IDX_W-1:0]             issue_ff, issue_in;
   logic                         issuing_ff, issuing_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]             rd_idx_ff, rd_idx_in;
   logic                         res_hit_ff, res_hit_in;
   logic [lksc_pkg::SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic                         res_evicted_ff, res_evicted_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lksc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [lksc_pkg::KEY_W-1:0]    req_surface;
   logic [lksc_pkg::KEY_W-1:0]    req_generation;
   logic [lksc_pkg::TARGET_W-1:0] req_target;
   logic [CMP_W-1:0]              target_wide;

   logic                         scan_start;
   logic                         wr_key_en;
   logic                         wr_stamp_en;
   logic [lksc_pkg::KEY_W-1:0]   rd_surface;
   logic [lksc_pkg::KEY_W-1:0]   rd_generation;
   logic [lksc_pkg::STAMP_W-1:0] rd_stamp;
   logic [IDX_W-1:0]             pick_idx;
   lksc_pkg::pick_type           pick;

   assign req_surface    = req_tdata[63:0];
   assign req_generation = req_tdata[127:64];
   assign req_target     = req_tdata[130:128];
   assign target_wide    = {4'b0000, req_target};

   lksc_store #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_store (
      .clock         (clock),
      .wr_key_en     (wr_key_en),
      .wr_stamp_en   (wr_stamp_en),
      .wr_addr       (pick_idx),
      .wr_surface    (surface_ff),
      .wr_generation (generation_ff),
      .wr_stamp      (counter_ff),
      .rd_addr       (issue_ff),
      .rd_surface    (rd_surface),
      .rd_generation (rd_generation),
      .rd_stamp      (rd_stamp)
   );

   lksc_scan #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .start          (scan_start),
      .step           (rd_valid_ff),
      .step_idx       (rd_idx_ff),
      .step_valid     (valid_ff[rd_idx_ff]),
      .req_surface    (surface_ff),
      .req_generation (generation_ff),
      .rd_surface     (rd_surface),
      .rd_generation  (rd_generation),
      .rd_stamp       (rd_stamp),
      .pick_idx       (pick_idx),
      .pick           (pick)
   );

   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      counter_in     = counter_ff;
      surface_in     = surface_ff;
      generation_in  = generation_ff;
      issue_in       = issue_ff;
      issuing_in     = issuing_ff;
      rd_valid_in    = 1'b0;
      rd_idx_in      = rd_idx_ff;
      res_hit_in     = res_hit_ff;
      res_slot_in    = res_slot_ff;
      res_evicted_in = res_evicted_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      req_tready     = 1'b0;
      scan_start     = 1'b0;
      wr_key_en      = 1'b0;
      wr_stamp_en    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         lksc_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            res_hit_in     = 1'b0;
            res_slot_in    = '0;
            res_evicted_in = 1'b0;
            if (req_tvalid) begin
               case (lksc_pkg::func_type'(req_tuser))
                  lksc_pkg::FUNC_LOOKUP: begin
                     counter_in    = counter_ff + 1'b1;
                     surface_in    = req_surface;
                     generation_in = req_generation;
                     issue_in      = '0;
                     issuing_in    = 1'b1;
                     scan_start    = 1'b1;
                     state_in      = lksc_pkg::ST_SCAN;
                  end
                  lksc_pkg::FUNC_INVALIDATE: begin
                     for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (CMP_W'(i) == target_wide) begin
                           valid_in[i] = 1'b0;
                        end
                     end
                     state_in = lksc_pkg::ST_HOLD;
                  end
                  lksc_pkg::FUNC_CLEAR: begin
                     valid_in = '0;
                     state_in = lksc_pkg::ST_HOLD;
                  end
                  default: begin
                     state_in = lksc_pkg::ST_HOLD;
                  end
               endcase
            end
         end
         lksc_pkg::ST_SCAN: begin
            rd_valid_in = issuing_ff;
            rd_idx_in   = issue_ff;
            if (issuing_ff) begin
               issue_in = issue_ff + 1'b1;
               if (issue_ff == IDX_W'(NUM_SLOTS - 1)) begin
                  issuing_in = 1'b0;
               end
            end else if (!rd_valid_ff) begin
               state_in = lksc_pkg::ST_WRITE;
            end
         end
         lksc_pkg::ST_WRITE: begin
            wr_stamp_en        = 1'b1;
            wr_key_en          = !pick.hit;
            valid_in[pick_idx] = 1'b1;
            res_hit_in         = pick.hit;
            res_slot_in        = lksc_pkg::SLOT_W'(pick_idx);
            res_evicted_in     = pick.evicted;
            state_in           = lksc_pkg::ST_HOLD;
         end
         lksc_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_evicted_ff, res_slot_ff, res_hit_ff};
               state_in     = lksc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lksc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lksc_pkg::ST_IDLE;
         valid_ff     <= '0;
         counter_ff   <= '0;
         issuing_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         counter_ff   <= counter_in;
         issuing_ff   <= issuing_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      surface_ff     <= surface_in;
      generation_ff  <= generation_in;
      issue_ff       <= issue_in;
      rd_idx_ff      <= rd_idx_in;
      res_hit_ff     <= res_hit_in;
      res_slot_ff    <= res_slot_in;
      res_evicted_ff <= res_evicted_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // scan fully drained before the table is written
   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == lksc_pkg::ST_WRITE |-> !issuing_ff && !rd_valid_ff)
      else $error("table write with scan still in flight");

   // the returned slot holds a live entry afterwards
   a_slot_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == lksc_pkg::ST_WRITE |=> valid_ff[$past(pick_idx)])
      else $error("returned slot not valid after lookup");

   // clear empties every slot
   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == lksc_pkg::FUNC_CLEAR) |=> valid_ff == '0)
      else $error("slots left valid after clear");

   // only lookups move the use counter
   a_counter_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser != lksc_pkg::FUNC_LOOKUP) |=>
      $stable(counter_ff))
      else $error("use counter moved on a non-lookup request");

endmodule

/* rtl/lksc_store.sv */
module lksc_store #(
   parameter int NUM_SLOTS = lksc_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           wr_key_en,
   input  logic                           wr_stamp_en,
   input  logic [$clog2(NUM_SLOTS)-1:0]   wr_addr,
   input  logic [lksc_pkg::KEY_W-1:0]     wr_surface,
   input  logic [lksc_pkg::KEY_W-1:0]     wr_generation,
   input  logic [lksc_pkg::STAMP_W-1:0]   wr_stamp,
   input  logic [$clog2(NUM_SLOTS)-1:0]   rd_addr,
   output logic [lksc_pkg::KEY_W-1:0]     rd_surface,
   output logic [lksc_pkg::KEY_W-1:0]     rd_generation,
   output logic [lksc_pkg::STAMP_W-1:0]   rd_stamp
);

   logic [lksc_pkg::KEY_W-1:0]   surface_mem    [NUM_SLOTS];
   logic [lksc_pkg::KEY_W-1:0]   generation_mem [NUM_SLOTS];
   logic [lksc_pkg::STAMP_W-1:0] stamp_mem      [NUM_SLOTS];

   logic [lksc_pkg::KEY_W-1:0]   rd_surface_ff;
   logic [lksc_pkg::KEY_W-1:0]   rd_generation_ff;
   logic [lksc_pkg::STAMP_W-1:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         surface_mem[wr_addr]    <= wr_surface;
         generation_mem[wr_addr] <= wr_generation;
      end
      if (wr_stamp_en) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
      rd_surface_ff    <= surface_mem[rd_addr];
      rd_generation_ff <= generation_mem[rd_addr];
      rd_stamp_ff      <= stamp_mem[rd_addr];
   end

   assign rd_surface    = rd_surface_ff;
   assign rd_generation = rd_generation_ff;
   assign rd_stamp      = rd_stamp_ff;

endmodule

/* rtl/lksc_scan.sv */
module lksc_scan #(
   parameter int NUM_SLOTS = lksc_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           step,
   input  logic [$clog2(NUM_SLOTS)-1:0]   step_idx,
   input  logic                           step_valid,
   input  logic [lksc_pkg::KEY_W-1:0]     req_surface,
   input  logic [lksc_pkg::KEY_W-1:0]     req_generation,
   input  logic [lksc_pkg::KEY_W-1:0]     rd_surface,
   input  logic [lksc_pkg::KEY_W-1:0]     rd_generation,
   input  logic [lksc_pkg::STAMP_W-1:0]   rd_stamp,
   output logic [$clog2(NUM_SLOTS)-1:0]   pick_idx,
   output lksc_pkg::pick_type             pick
);

   localparam int IDX_W = $clog2(NUM_SLOTS);

   logic                         hit_ff,       hit_in;
   logic [IDX_W-1:0]             hit_idx_ff,   hit_idx_in;
   logic                         empty_ff,     empty_in;
   logic [IDX_W-1:0]             empty_idx_ff, empty_idx_in;
   logic [IDX_W-1:0]             lru_idx_ff,   lru_idx_in;
   logic [lksc_pkg::STAMP_W-1:0] lru_stamp_ff, lru_stamp_in;
   logic                         match;
   logic                         older;

   assign match = step_valid && (rd_surface == req_surface) &&
                  (rd_generation == req_generation);
   assign older = (step_idx == '0) || (rd_stamp < lru_stamp_ff);

   always_comb begin
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      lru_idx_in   = lru_idx_ff;
      lru_stamp_in = lru_stamp_ff;
      if (start) begin
         hit_in   = 1'b0;
         empty_in = 1'b0;
      end else if (step) begin
         if (match && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = step_idx;
         end
         if (!step_valid && !empty_ff) begin
            empty_in     = 1'b1;
            empty_idx_in = step_idx;
         end
         if (older) begin
            lru_idx_in   = step_idx;
            lru_stamp_in = rd_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         hit_ff   <= hit_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      empty_idx_ff <= empty_idx_in;
      lru_idx_ff   <= lru_idx_in;
      lru_stamp_ff <= lru_stamp_in;
   end

   assign pick_idx    = hit_ff ? hit_idx_ff : (empty_ff ? empty_idx_ff : lru_idx_ff);
   assign pick.hit     = hit_ff;
   assign pick.evicted = !hit_ff && !empty_ff;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import lksc_pkg::*;

   localparam int SLOTS          = NUM_SLOTS_DEFAULT;
   localparam int POOL_SIZE      = 12;
   localparam int RANDOM_ITEMS   = 800;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   typedef struct {
      logic             hit;
      logic [SLOT_W-1:0] slot;
      logic             evicted;
   } slot_result;

   class slot_cache_scoreboard;
      bit                 entry_valid[SLOTS];
      logic [KEY_W-1:0]   entry_surface[SLOTS];
      logic [KEY_W-1:0]   entry_generation[SLOTS];
      logic [STAMP_W-1:0] entry_stamp[SLOTS];
      logic [STAMP_W-1:0] use_count;
      slot_result         expected_q[$];
      int                 errors;

      function void reset_state();
         for (int i = 0; i < SLOTS; i++) begin
            entry_valid[i]      = 1'b0;
            entry_surface[i]    = '0;
            entry_generation[i] = '0;
            entry_stamp[i]      = '0;
         end
         use_count = '0;
         errors    = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // lru victim: lowest empty slot, else oldest stamp with lowest index on a tie
      function int pick_victim(output bit was_valid);
         int oldest;
         oldest = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (!entry_valid[i]) begin
               was_valid = 1'b0;
               return i;
            end
         end
         for (int i = 1; i < SLOTS; i++) begin
            if (entry_stamp[i] < entry_stamp[oldest]) oldest = i;
         end
         was_valid = 1'b1;
         return oldest;
      endfunction

      function void note_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] skey,
                                 logic [KEY_W-1:0] gkey, logic [TARGET_W-1:0] target);
         slot_result res;
         int         idx;
         bit         found;
         bit         was_valid;
         res   = '{hit: 1'b0, slot: '0, evicted: 1'b0};
         idx   = 0;
         found = 1'b0;
         if (func == FUNC_LOOKUP) begin
            use_count = use_count + 1;
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && entry_valid[i] && entry_surface[i] == skey &&
                   entry_generation[i] == gkey) begin
                  found = 1'b1;
                  idx   = i;
               end
            end
            if (found) begin
               res.hit = 1'b1;
            end else begin
               idx = pick_victim(was_valid);
               res.evicted = was_valid;
               entry_valid[idx]      = 1'b1;
               entry_surface[idx]    = skey;
               entry_generation[idx] = gkey;
            end
            entry_stamp[idx] = use_count;
            res.slot = SLOT_W'(idx);
         end else if (func == FUNC_INVALIDATE) begin
            if (int'(target) < SLOTS) entry_valid[target] = 1'b0;
         end else if (func == FUNC_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) entry_valid[i] = 1'b0;
         end
         expected_q.push_back(res);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         slot_result exp_res;
         slot_result got;
         got.hit     = data[0];
         got.slot    = data[3:1];
         got.evicted = data[4];
         if (expected_q.size() == 0) begin
            $display("%0t: response with none pending: hit %0b slot %0d evicted %0b",
                     $time, got.hit, got.slot, got.evicted);
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (got.hit !== exp_res.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, exp_res.hit, got.hit);
            errors++;
         end
         if (got.slot !== exp_res.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, exp_res.slot, got.slot);
            errors++;
         end
         if (got.evicted !== exp_res.evicted) begin
            $display("%0t: evicted expected %0b actual %0b",
                     $time, exp_res.evicted, got.evicted);
            errors++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic [FUNC_W-1:0]       req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   slot_cache_scoreboard cache_sb;
   int                   idle_pct;
   bit                   hold_request;
   int                   idle_cycles;
   logic [KEY_W-1:0]     pool_surface[POOL_SIZE];
   logic [KEY_W-1:0]     pool_generation[POOL_SIZE];

   lru_keyed_slot_cache #(.NUM_SLOTS(SLOTS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_W-1:0] rand_surface();
      logic [KEY_W-1:0] k;
      k = rand_key();
      if (k == '0) k = 64'd1;
      return k;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] skey,
                               input logic [KEY_W-1:0] gkey,
                               input logic [TARGET_W-1:0] target);
      int gap;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 15);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = {5'b0, target, gkey, skey};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cache_sb.note_request(func, skey, gkey, target);
      @(negedge clock);
   endtask

   task automatic lookup(input logic [KEY_W-1:0] skey, input logic [KEY_W-1:0] gkey);
      send_request(FUNC_LOOKUP, skey, gkey, TARGET_W'($urandom));
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (cache_sb.pending() != 0) @(negedge clock);
   endtask

   // result side
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) cache_sb.check_response(rsp_tdata);
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("testbench failed");
      $finish;
   end

   initial begin
      int roll;
      int pick;
      cache_sb = new();
      cache_sb.reset_state();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = FUNC_LOOKUP;
      idle_pct     = 0;
      hold_request = 1'b0;
      for (int k = 0; k < POOL_SIZE; k += 2) begin
         pool_surface[k]       = rand_surface();
         pool_surface[k + 1]   = pool_surface[k];
         pool_generation[k]    = rand_key();
         pool_generation[k + 1] = pool_generation[k] ^ (64'd1 << $urandom_range(0, 63));
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // key extremes, hits and key halves differing
      lookup('1, '1);
      lookup(64'd1, '0);
      lookup('1, '1);
      lookup('1, '0);
      lookup(64'd1, '1);
      // fill the table, then force lru evictions
      for (int k = 2; k < 5; k++) lookup(KEY_W'(k), KEY_W'(k));
      lookup(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
      lookup(64'd1, '0);
      lookup(64'h55, 64'h55);
      lookup(64'h66, 64'h66);
      // invalidate at both ends, refill lowest empty
      send_request(FUNC_INVALIDATE, rand_key(), rand_key(), 3'd0);
      send_request(FUNC_INVALIDATE, rand_key(), rand_key(), 3'd7);
      lookup(64'h77, 64'h77);
      lookup(64'h88, 64'h88);
      lookup('1, '1);
      // unused code leaves state alone
      send_request(FUNC_SPARE, '1, '1, 3'd7);
      lookup(64'h88, 64'h88);
      // clear then old key misses
      send_request(FUNC_CLEAR, rand_key(), rand_key(), TARGET_W'($urandom));
      lookup(64'h88, 64'h88);
      lookup(64'h88, 64'h88);
      wait_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 20;
               default: idle_pct = 50;
            endcase
         end
         if (n >= RANDOM_ITEMS - 100) idle_pct = 0;
         if (n == 250) begin
            wait_drained();
            hold_request = 1'b1;
         end
         if (n == 500) wait_drained();
         roll = $urandom_range(0, 99);
         if (roll < 72) begin
            pick = $urandom_range(0, POOL_SIZE - 1);
            lookup(pool_surface[pick], pool_generation[pick]);
         end else if (roll < 80) begin
            lookup(rand_surface(), rand_key());
         end else if (roll < 90) begin
            send_request(FUNC_INVALIDATE, rand_surface(), rand_key(), TARGET_W'($urandom));
         end else if (roll < 95) begin
            send_request(FUNC_CLEAR, rand_surface(), rand_key(), TARGET_W'($urandom));
         end else begin
            send_request(FUNC_SPARE, rand_surface(), rand_key(), TARGET_W'($urandom));
         end
      end

      wait_drained();
      repeat (SLOTS + 8) @(negedge clock);
      if (cache_sb.errors == 0 && cache_sb.pending() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

/* lru_keyed_slot_cache.f */
rtl/lksc_pkg.sv
rtl/lksc_store.sv
rtl/lksc_scan.sv
rtl/lru_keyed_slot_cache.sv
verif/testbench.sv
